/* src/fmc_pkg.sv */
package fmc_pkg;

  // FNV-1a constants for a 32-bit digest, and the bit that tags a digest.
  localparam int unsigned DIGEST_W = 32;
  localparam logic [DIGEST_W-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [DIGEST_W-1:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [DIGEST_W-1:0] TAG_BIT   = 32'h8000_0000;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned CNT_W = 32;

  // A tagged digest on its way from the hash stage to the table.
  typedef struct packed {
    logic                vld;
    logic [DIGEST_W-1:0] tag;
  } probe_t;

  // One lookup result; hit sits in the lowest bit when packed.
  typedef struct packed {
    logic [CNT_W-1:0] skips_total;
    logic [CNT_W-1:0] misses_total;
    logic [CNT_W-1:0] hits_total;
    logic             skip;
    logic             hit;
  } result_t;

  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned RES_PAD     = OUT_TDATA_W - $bits(result_t);

endpackage

/* src/fnv1a_direct_mapped_memo_cache.sv */
// FNV-1a memoization probe. Key bytes stream in one per cycle while
// in_tready is high; the byte flagged by in_tlast closes the key and
// produces one result, while every other byte produces none. The
// pipeline (hash fold, two-step slot reduction, table read, compare and
// write-back) takes a byte every cycle as long as the result register is
// free or being emptied; back-to-back keys that hit the same slot are
// handled by forwarding the latest write-back. After reset the table is
// cleared one entry per cycle, and in_tready stays low until every entry
// is cleared; configuration writes are taken at any time with cfg_ready
// tied high, but should be made only while no key is in flight.
module fnv1a_direct_mapped_memo_cache #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Key stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] key_byte
  input  logic                            in_tlast,   // last_byte
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] hit, [1] skip, [33:2] hits_total, [65:34] misses_total,
  // [97:66] skips_total, [103:98] zero
  output logic [fmc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data    // skip_on_hit
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic             adv;
  logic             in_fire;
  logic             clr_busy;
  logic             skip_on_hit_r;
  fmc_pkg::probe_t  hash_probe;
  fmc_pkg::probe_t  slot_probe;
  logic [IDX_W-1:0] slot;
  logic             res_vld;
  fmc_pkg::result_t res;

  // The whole pipeline moves when the result register can take a value.
  assign adv       = !res_vld || out_tready;
  assign in_tready = adv && !clr_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_on_hit_r <= 1'b0;
    end else if (cfg_valid) begin
      skip_on_hit_r <= cfg_data;
    end
  end

  fmc_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_fire   (in_fire),
    .key_byte  (in_tdata),
    .last_byte (in_tlast),
    .probe_o   (hash_probe)
  );

  fmc_slot #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_slot (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .probe_i (hash_probe),
    .probe_o (slot_probe),
    .slot_o  (slot)
  );

  fmc_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .probe_i     (slot_probe),
    .slot_i      (slot),
    .skip_on_hit (skip_on_hit_r),
    .clr_busy    (clr_busy),
    .res_vld     (res_vld),
    .res         (res)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = {{fmc_pkg::RES_PAD{1'b0}}, res};

endmodule

/* src/fmc_hash.sv */
module fmc_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_fire,
  input  logic [fmc_pkg::KEY_W-1:0] key_byte,
  input  logic                      last_byte,
  output fmc_pkg::probe_t           probe_o
);

  logic [fmc_pkg::DIGEST_W-1:0] digest_r;
  logic [fmc_pkg::DIGEST_W-1:0] mixed;
  logic [fmc_pkg::DIGEST_W-1:0] folded;
  fmc_pkg::probe_t              probe_r;

  // Fold one byte: xor into the low bits, then multiply by the prime.
  always_comb begin
    mixed  = digest_r ^ {{(fmc_pkg::DIGEST_W - fmc_pkg::KEY_W){1'b0}}, key_byte};
    folded = mixed * fmc_pkg::FNV_PRIME;
  end

  // Running digest restarts from the basis after the last byte of a key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digest_r <= fmc_pkg::FNV_BASIS;
    end else if (in_fire) begin
      digest_r <= last_byte ? fmc_pkg::FNV_BASIS : folded;
    end
  end

  // Tagged digest goes downstream only for the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else if (adv) begin
      probe_r.vld <= in_fire & last_byte;
    end
    if (adv) begin
      probe_r.tag <= folded | fmc_pkg::TAG_BIT;
    end
  end

  assign probe_o = probe_r;

endmodule

/* src/fmc_slot.sv */
module fmc_slot #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  fmc_pkg::probe_t                probe_i,
  output fmc_pkg::probe_t                probe_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot_o
);

  localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned RECIP_SH = fmc_pkg::DIGEST_W + IDX_W;
  localparam logic [63:0] SH_ONE   = 64'd1 << RECIP_SH;
  // Rounded-up reciprocal: exact quotient for every 32-bit dividend.
  localparam logic [32:0] RECIP_M  = 33'((SH_ONE + 64'(TABLE_DEPTH) - 64'd1)
                                         / 64'(TABLE_DEPTH));

  logic [64:0]                  prod;
  logic [31:0]                  quot_nxt;
  logic [31:0]                  quot_r;
  fmc_pkg::probe_t              q_probe_r;
  logic [48:0]                  qd;
  logic [fmc_pkg::DIGEST_W-1:0] rem;
  logic [IDX_W-1:0]             slot_nxt;
  logic [IDX_W-1:0]             slot_r;
  fmc_pkg::probe_t              s_probe_r;

  // Stage one: quotient of the tagged digest by the table depth.
  always_comb begin
    prod     = 65'(probe_i.tag) * 65'(RECIP_M);
    quot_nxt = 32'(prod >> RECIP_SH);
  end

  // Stage two: remainder is the slot index.
  always_comb begin
    qd       = 49'(quot_r) * 49'(TABLE_DEPTH);
    rem      = q_probe_r.tag - qd[fmc_pkg::DIGEST_W-1:0];
    slot_nxt = rem[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_probe_r.vld <= 1'b0;
      s_probe_r.vld <= 1'b0;
    end else if (adv) begin
      q_probe_r.vld <= probe_i.vld;
      s_probe_r.vld <= q_probe_r.vld;
    end
    if (adv) begin
      quot_r        <= quot_nxt;
      q_probe_r.tag <= probe_i.tag;
      slot_r        <= slot_nxt;
      s_probe_r.tag <= q_probe_r.tag;
    end
  end

  assign probe_o = s_probe_r;
  assign slot_o  = slot_r;

endmodule

/* src/fmc_lookup.sv */
module fmc_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  fmc_pkg::probe_t                probe_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] slot_i,
  input  logic                           skip_on_hit,
  output logic                           clr_busy,
  output logic                           res_vld,
  output fmc_pkg::result_t               res
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [fmc_pkg::DIGEST_W-1:0] mem [TABLE_DEPTH];

  logic                         clr_busy_r;
  logic [IDX_W-1:0]             clr_idx_r;
  logic                         d_vld_r;
  logic [IDX_W-1:0]             d_slot_r;
  logic [fmc_pkg::DIGEST_W-1:0] d_tag_r;
  logic [fmc_pkg::DIGEST_W-1:0] rd_data_r;
  logic                         w_vld_r;
  logic [IDX_W-1:0]             w_slot_r;
  logic [fmc_pkg::DIGEST_W-1:0] w_tag_r;
  logic [fmc_pkg::DIGEST_W-1:0] stored;
  logic                         hit;
  logic                         skip;
  logic [fmc_pkg::CNT_W-1:0]    hits_r;
  logic [fmc_pkg::CNT_W-1:0]    misses_r;
  logic [fmc_pkg::CNT_W-1:0]    skips_r;
  logic [fmc_pkg::CNT_W-1:0]    hits_nxt;
  logic [fmc_pkg::CNT_W-1:0]    misses_nxt;
  logic [fmc_pkg::CNT_W-1:0]    skips_nxt;
  logic                         res_vld_r;
  fmc_pkg::result_t             res_r;

  // Clearing pass after reset: one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Table: one write port (clear or lookup write-back), one registered read.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (adv && d_vld_r) begin
      mem[d_slot_r] <= d_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= mem[slot_i];
    end
  end

  // Compare stage and the last write-back, kept for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= probe_i.vld;
      w_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_slot_r <= slot_i;
      d_tag_r  <= probe_i.tag;
      w_slot_r <= d_slot_r;
      w_tag_r  <= d_tag_r;
    end
  end

  // A write-back at the same edge as this read is not in the read data yet.
  always_comb begin
    stored     = (w_vld_r && (w_slot_r == d_slot_r)) ? w_tag_r : rd_data_r;
    hit        = (stored == d_tag_r);
    skip       = hit & skip_on_hit;
    hits_nxt   = hit  ? hits_r + 1'b1   : hits_r;
    misses_nxt = !hit ? misses_r + 1'b1 : misses_r;
    skips_nxt  = skip ? skips_r + 1'b1  : skips_r;
  end

  // Running counters, wrapping at 32 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      skips_r  <= '0;
    end else if (adv && d_vld_r) begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      skips_r  <= skips_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld_r) begin
      res_r.hit          <= hit;
      res_r.skip         <= skip;
      res_r.hits_total   <= hits_nxt;
      res_r.misses_total <= misses_nxt;
      res_r.skips_total  <= skips_nxt;
    end
  end

  assign clr_busy = clr_busy_r;
  assign res_vld  = res_vld_r;
  assign res      = res_r;

endmodule

/* src/fmc_checker.sv */
module fmc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fmc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // No result survives reset.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The table clear holds off the key stream right after reset.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("key accepted during table clear");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A skip is only ever reported on a hit.
  a_skip_hit: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (!out_tdata[1] || out_tdata[0]))
    else $error("skip without hit");

  // A stalled result register stalls the whole pipeline.
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |-> !in_tready)
    else $error("key accepted while result stalled");

endmodule

bind fnv1a_direct_mapped_memo_cache fmc_checker u_fmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
